@@ design/itoa_pkg.sv @@
// Shared constants, types and helpers for the integer-to-ASCII converter.
// Used by the divider, the character emitter and the top level.
package itoa_pkg;

  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned BIT_CNT_W   = $clog2(VALUE_BITS);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] DEC_RADIX  = 8'd10;

  // One write into the digit store.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  // Start request for the emitter.
  typedef struct packed {
    logic             start;
    logic             minus;
    logic [CNT_W-1:0] count;
  } emit_req_t;

  // Map a digit value to its character; high digits wrap modulo 256.
  function automatic logic [7:0] digit_char(input logic [7:0] d);
    logic [7:0] c;
    if (d < DEC_RADIX) begin
      c = d + CHAR_ZERO;
    end else begin
      c = d + (CHAR_A - DEC_RADIX);
    end
    return c;
  endfunction

endpackage

@@ design/integer_to_ascii_radix_top.sv @@
// Integer to ASCII in any radix from 2 to 255; a radix below 2 selects decimal.
// Each digit costs one pass of the bit-serial divider; each character is then
// read from the digit store and loaded into the output register.
// A new item is taken once the previous one's last character is registered.
// Reset is asynchronous and active low; the digit store is not cleared.
module integer_to_ascii_radix_top
  import itoa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [7:0]            radix_i,
  input  logic                  is_signed_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            char_out_o,
  output logic                  last_o
);

  typedef enum logic {
    T_IDLE,
    T_DIV
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      count_q;
  logic                  minus_q;
  logic [7:0]            radix_q;
  logic                  emit_busy;
  logic                  in_take;
  logic                  neg;
  logic [7:0]            radix_eff;
  logic [VALUE_BITS-1:0] magnitude;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [7:0]            div_divisor;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [7:0]            div_rem;
  logic                  room;
  logic [CNT_W-1:0]      count_next;
  store_wr_t             wr;
  emit_req_t             req;

  assign in_ready_o = (state_q == T_IDLE) && !emit_busy;
  assign in_take    = in_valid_i && in_ready_o;

  // Sign and radix handling at input.
  assign neg       = is_signed_i && (radix_i == DEC_RADIX) && value_i[VALUE_BITS-1];
  assign radix_eff = (radix_i < 8'd2) ? DEC_RADIX : radix_i;
  assign magnitude = neg ? (~value_i + 1'b1) : value_i;

  // Divider start: from the input, or chained on the running quotient.
  assign div_start    = in_take || ((state_q == T_DIV) && div_done && (div_quot != '0));
  assign div_dividend = in_take ? magnitude : div_quot;
  assign div_divisor  = in_take ? radix_eff : radix_q;

  // Store the new digit while there is room; count saturates at the depth.
  assign room       = !count_q[CNT_W-1];
  assign count_next = room ? count_q + 1'b1 : count_q;

  always_comb begin
    wr.en     = (state_q == T_DIV) && div_done && room;
    wr.addr   = count_q[IDX_W-1:0];
    wr.data   = digit_char(div_rem);
    req.start = (state_q == T_DIV) && div_done && (div_quot == '0);
    req.minus = minus_q;
    req.count = count_next;
  end

  // Conversion control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      count_q <= '0;
      minus_q <= 1'b0;
      radix_q <= '0;
    end else begin
      unique case (state_q)
        T_IDLE: begin
          if (in_take) begin
            count_q <= '0;
            minus_q <= neg;
            radix_q <= radix_eff;
            state_q <= T_DIV;
          end
        end
        T_DIV: begin
          if (div_done) begin
            count_q <= count_next;
            if (div_quot == '0) begin
              state_q <= T_IDLE;
            end
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  itoa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot),
    .remainder_o(div_rem)
  );

  itoa_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .req_i      (req),
    .busy_o     (emit_busy),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_out_o (char_out_o),
    .last_o     (last_o)
  );

endmodule

@@ design/itoa_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on itoa_pkg for VALUE_BITS and the bit counter width.
module itoa_div
  import itoa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [7:0]            divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic [7:0]            remainder_o
);

  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [7:0]            rem_q, rem_d;
  logic [7:0]            div_q;
  logic [BIT_CNT_W-1:0]  cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [8:0]            rem_sh;
  logic                  fits;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    rem_sh = {rem_q, quot_q[VALUE_BITS-1]};
    fits   = (rem_sh >= {1'b0, div_q});
    rem_d  = fits ? 8'(rem_sh - {1'b0, div_q}) : rem_sh[7:0];
    quot_d = {quot_q[VALUE_BITS-2:0], fits};
  end

  // Control: step counter, busy and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quot_q <= dividend_i;
      end else if (busy_q) begin
        quot_q <= quot_d;
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == BIT_CNT_W'(VALUE_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and divisor hold no control state.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quot_q;
  assign remainder_o = rem_q;

endmodule

@@ design/itoa_emit.sv @@
// Digit store and character emitter with a registered output stage.
// Depends on itoa_pkg for the store write and start request types.
module itoa_emit
  import itoa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  store_wr_t wr_i,
  input  emit_req_t req_i,
  output logic      busy_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic [7:0] char_out_o,
  output logic      last_o
);

  typedef enum logic [1:0] {
    E_IDLE,
    E_SIGN,
    E_READ,
    E_LOAD
  } state_e;

  logic [7:0]       mem [STORE_DEPTH];
  logic [7:0]       rd_data_q;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] idx_dec;
  logic             out_valid_q;
  logic [7:0]       char_q;
  logic             last_q;
  logic             slot_free;
  logic             out_load;
  state_e           state_q;

  assign idx_dec   = idx_q - 1'b1;
  assign rd_addr   = idx_dec[IDX_W-1:0];
  assign rd_en     = (state_q == E_READ);
  assign slot_free = !out_valid_q || out_ready_i;
  assign out_load  = slot_free && ((state_q == E_SIGN) || (state_q == E_LOAD));

  // Digit store: one write port from the converter, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Emitter sequence and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= E_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      // The output register fills on a load and empties when its item is taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        E_IDLE: begin
          if (req_i.start) begin
            idx_q   <= req_i.count;
            state_q <= req_i.minus ? E_SIGN : E_READ;
          end
        end
        E_SIGN: begin
          if (slot_free) begin
            char_q      <= CHAR_MINUS;
            last_q      <= 1'b0;
            state_q     <= E_READ;
          end
        end
        E_READ: begin
          state_q <= E_LOAD;
        end
        E_LOAD: begin
          if (slot_free) begin
            char_q      <= rd_data_q;
            last_q      <= (idx_q == CNT_W'(1));
            idx_q       <= idx_dec;
            state_q     <= (idx_q == CNT_W'(1)) ? E_IDLE : E_READ;
          end
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != E_IDLE);
  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign last_o      = last_q;

endmodule

@@ design/itoa_chk.sv @@
// Port-level checker for the integer-to-ASCII converter, bound to the top.
// Depends on itoa_pkg for VALUE_BITS.
module itoa_chk
  import itoa_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [VALUE_BITS-1:0] value_i,
  input logic [7:0]            radix_i,
  input logic                  is_signed_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [7:0]            char_out_o,
  input logic                  last_o
);

  // A waiting input item holds its value until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(value_i) && $stable(radix_i)
      && $stable(is_signed_i))
    else $error("input item changed while waiting");

  // A stalled output item holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_out_o) && $stable(last_o))
    else $error("output item changed while stalled");

  // After an item is taken the converter is busy and does not take another.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken again while converting");

  // The final character taken leaves the output empty.
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> !out_valid_o)
    else $error("output item after the last character");

  // No new output item appears in the cycle right after an input is taken
  // unless one was already waiting.
  a_no_early_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("character emitted before any digit was found");

endmodule

bind integer_to_ascii_radix_top itoa_chk u_chk (.*);
